>>> sv/fpalu_pkg.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU package
// Shared widths, defaults and command codes for the fixed-point ALU.
// ---------------------------------------------------------------------------
package fpalu_pkg;

   localparam int DATA_W            = 32;
   localparam int CMD_W             = 4;
   localparam int FRACTION_BITS_DEF = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_INC      = 4'd4,
      CMD_DEC      = 4'd5,
      CMD_MIN      = 4'd6,
      CMD_MAX      = 4'd7,
      CMD_TO_INT   = 4'd8,
      CMD_FROM_INT = 4'd9
   } cmd_type;

endpackage

>>> sv/fpalu_ifs.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU channels
// Request and response valid/ready channels of the fixed-point ALU.
// ---------------------------------------------------------------------------
interface fpalu_req_if;
   logic                                    valid;
   logic                                    ready;
   logic        [fpalu_pkg::CMD_W-1:0]      command;
   logic signed [fpalu_pkg::DATA_W-1:0]     operand_a;
   logic signed [fpalu_pkg::DATA_W-1:0]     operand_b;

   modport source (output valid, command, operand_a, operand_b, input ready);
   modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fpalu_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [fpalu_pkg::DATA_W-1:0]     result;
   logic                                    a_less;
   logic                                    a_equal;
   logic                                    a_greater;
   logic                                    overflow;
   logic                                    divide_by_zero;

   modport source (output valid, result, a_less, a_equal, a_greater, overflow,
                   divide_by_zero, input ready);
   modport sink   (input valid, result, a_less, a_equal, a_greater, overflow,
                   divide_by_zero, output ready);
endinterface

>>> sv/fixed_point_alu_core.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU core
// Signed fixed-point add, sub, mul, div, inc, dec, min, max and conversions
// with saturation, rounding half away from zero on mul and div, and A/B compare flags.
// ---------------------------------------------------------------------------
// Throughput: one beat per cycle while the response is not stalled; the 32-stage
// restoring divider chain sets the depth, each stage one compare-subtract on a 64-bit remainder.
// A stalled response freezes the whole pipe.
// Reset clears the stage valid bits only; no item is in flight after reset.
module fixed_point_alu_core #(
   parameter int FRACTION_BITS = fpalu_pkg::FRACTION_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   fpalu_req_if.sink    req_if,
   fpalu_rsp_if.source  rsp_if
);

   localparam int W         = fpalu_pkg::DATA_W;
   localparam int WW        = 2 * W;
   localparam int DIV_FIRST = 4;
   localparam int LAST      = DIV_FIRST + W;
   localparam int NST       = LAST + 1;

   localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [WW-1:0] HALF = (WW'(1) << FRACTION_BITS) >> 1;
   localparam logic [WW-1:0] LIM  = WW'(1) << (W-1);

   typedef struct packed {
      fpalu_pkg::cmd_type cmd;
      logic [W-1:0]       a;
      logic [W-1:0]       b;
      logic               less;
      logic               equal;
      logic               greater;
      logic               neg;
      logic               dz;
      logic               big;
      logic [W-1:0]       mag_a;
      logic [W-1:0]       mag_b;
      logic [WW-1:0]      wide;
      logic [W-1:0]       quo;
      logic [W-1:0]       res;
      logic               ovf;
   } stage_type;

   stage_type pipe_ff [NST];
   stage_type pipe_in [NST];
   logic      vld_ff  [NST];
   logic      adv;

   // {ovf, value} of a sign/magnitude number clipped to the signed range
   function automatic logic [W:0] sat_mag(input logic neg, input logic [WW-1:0] mag);
      logic [WW-1:0] nmag;
      nmag = ~mag + WW'(1);
      if (neg) begin
         if (mag > LIM) return {1'b1, MINV};
         return {1'b0, nmag[W-1:0]};
      end
      if (mag > LIM - WW'(1)) return {1'b1, MAXV};
      return {1'b0, mag[W-1:0]};
   endfunction

   function automatic logic [W:0] sat_sum(input logic [W:0] s);
      if (s[W] != s[W-1]) return {1'b1, (s[W] ? MINV : MAXV)};
      return {1'b0, s[W-1:0]};
   endfunction

   assign adv           = !vld_ff[LAST] || rsp_if.ready;
   assign req_if.ready  = adv;
   assign rsp_if.valid  = vld_ff[LAST];
   assign rsp_if.result         = pipe_ff[LAST].res;
   assign rsp_if.a_less         = pipe_ff[LAST].less;
   assign rsp_if.a_equal        = pipe_ff[LAST].equal;
   assign rsp_if.a_greater      = pipe_ff[LAST].greater;
   assign rsp_if.overflow       = pipe_ff[LAST].ovf;
   assign rsp_if.divide_by_zero = pipe_ff[LAST].dz;

   always_comb begin
      stage_type     p;
      logic [W-1:0]  na;
      logic [W-1:0]  nb;
      logic [WW-1:0] dd;
      logic [W:0]    q;
      logic [W:0]    sr;

      // stage 0: capture
      pipe_in[0]       = '0;
      pipe_in[0].cmd   = fpalu_pkg::cmd_type'(req_if.command);
      pipe_in[0].a     = req_if.operand_a;
      pipe_in[0].b     = req_if.operand_b;

      // stage 1: compare, magnitudes, simple commands
      p         = pipe_ff[0];
      na        = ~p.a + W'(1);
      nb        = ~p.b + W'(1);
      p.less    = $signed(p.a) < $signed(p.b);
      p.equal   = p.a == p.b;
      p.greater = $signed(p.a) > $signed(p.b);
      p.neg     = p.a[W-1] ^ p.b[W-1];
      p.mag_a   = p.a[W-1] ? na : p.a;
      p.mag_b   = p.b[W-1] ? nb : p.b;
      p.dz      = (p.cmd == fpalu_pkg::CMD_DIV) && (p.b == '0);
      p.res     = '0;
      p.ovf     = 1'b0;
      sr        = '0;
      unique case (p.cmd)
         fpalu_pkg::CMD_ADD: sr = sat_sum({p.a[W-1], p.a} + {p.b[W-1], p.b});
         fpalu_pkg::CMD_SUB: sr = sat_sum({p.a[W-1], p.a} - {p.b[W-1], p.b});
         fpalu_pkg::CMD_INC: sr = sat_sum({p.a[W-1], p.a} + (W+1)'(1));
         fpalu_pkg::CMD_DEC: sr = sat_sum({p.a[W-1], p.a} - (W+1)'(1));
         fpalu_pkg::CMD_MIN: sr = {1'b0, (p.less ? p.a : p.b)};
         fpalu_pkg::CMD_MAX: sr = {1'b0, (p.greater ? p.a : p.b)};
         fpalu_pkg::CMD_TO_INT: sr = {1'b0, W'($signed(p.a) >>> FRACTION_BITS)};
         fpalu_pkg::CMD_FROM_INT:
            sr = sat_mag(p.a[W-1], WW'(p.mag_a) << FRACTION_BITS);
         default: sr = '0;
      endcase
      {p.ovf, p.res} = sr;
      pipe_in[1] = p;

      // stage 2: product, or scaled dividend and range check
      p     = pipe_ff[1];
      p.big = (WW'(p.mag_a) << FRACTION_BITS) >= (WW'(p.mag_b) << W);
      if (p.cmd == fpalu_pkg::CMD_MUL)
         p.wide = WW'(p.mag_a) * WW'(p.mag_b);
      else
         p.wide = WW'(p.mag_a) << FRACTION_BITS;
      pipe_in[2] = p;

      // stage 3: multiply rounding
      p     = pipe_ff[2];
      p.quo = '0;
      if (p.cmd == fpalu_pkg::CMD_MUL)
         {p.ovf, p.res} = sat_mag(p.neg, (p.wide + HALF) >> FRACTION_BITS);
      pipe_in[3] = p;

      // divider: one quotient bit per stage, msb first
      for (int k = 0; k < W; k++) begin
         p  = pipe_ff[DIV_FIRST + k - 1];
         dd = WW'(p.mag_b) << (W - 1 - k);
         if (p.wide >= dd) begin
            p.wide          = p.wide - dd;
            p.quo[W - 1 - k] = 1'b1;
         end
         pipe_in[DIV_FIRST + k] = p;
      end

      // final: divide rounding and saturation
      p = pipe_ff[LAST - 1];
      q = {1'b0, p.quo} + (W+1)'((p.wide << 1) >= WW'(p.mag_b));
      if (p.cmd == fpalu_pkg::CMD_DIV) begin
         if (p.dz) begin
            p.ovf = 1'b0;
            p.res = p.a[W-1] ? MINV : MAXV;
         end else if (p.big) begin
            p.ovf = 1'b1;
            p.res = p.neg ? MINV : MAXV;
         end else begin
            {p.ovf, p.res} = sat_mag(p.neg, WW'(q));
         end
      end
      pipe_in[LAST] = p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_if.valid;
         for (int k = 1; k < NST; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

endmodule

>>> sv/fpalu_checker.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU checker
// Port-level properties of the fixed-point ALU core, bound into the core module.
// ---------------------------------------------------------------------------
module fpalu_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic a_less,
   input logic a_equal,
   input logic a_greater,
   input logic overflow,
   input logic divide_by_zero
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled response dropped");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({a_less, a_equal, a_greater}))
      else $error("compare flags not exclusive");

   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && divide_by_zero |-> !overflow)
      else $error("overflow with divide by zero");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind fixed_point_alu_core fpalu_checker u_fpalu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .a_less         (rsp_if.a_less),
   .a_equal        (rsp_if.a_equal),
   .a_greater      (rsp_if.a_greater),
   .overflow       (rsp_if.overflow),
   .divide_by_zero (rsp_if.divide_by_zero)
);
